@@ src/deadzone_pressure_valve_control_macros.svh @@
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef DEADZONE_PRESSURE_VALVE_CONTROL_MACROS_SVH
`define DEADZONE_PRESSURE_VALVE_CONTROL_MACROS_SVH
`ifndef SYNTHESIS
`define DPVC_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define DPVC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define DPVC_ASSERT_IMPL(name, pre, post)
`define DPVC_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ src/dpvc_pkg.sv @@
`default_nettype none
package dpvc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W = 3;
    localparam int ADC_W = 12;
    localparam int TGT_W = 16;
    localparam int PROD_W = 28;
    localparam int PRESS_W = 20;
    localparam int ERR_W = 21;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] CHAN_MASK = 8'((1 << CHANNELS) - 1);
    localparam logic signed [14:0] PRESS_MUL = 15'sd9914;
    localparam logic signed [TGT_W-1:0] TARGET_LIMIT = 16'sd20480;

    localparam logic [14:0] DB_UPPER_RESET = 15'd2560;
    localparam logic signed [15:0] DB_LOWER_RESET = -16'sd2560;

    typedef enum logic [1:0] {
        REG_DB_UPPER  = 2'd0,
        REG_DB_LOWER  = 2'd1,
        REG_LOCK_MASK = 2'd2,
        REG_ENABLE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ARMED = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        LED_NONE   = 2'd0,
        LED_STEADY = 2'd1,
        LED_BLINK  = 2'd2
    } led_t;

    typedef struct packed {
        logic                    cmd;
        logic [CH_W-1:0]         channel;
        logic [ADC_W-1:0]        adc_value;
        logic [ADC_W-1:0]        zero_value;
        logic signed [TGT_W-1:0] target_pressure;
        logic                    last_channel;
    } sample_t;

    typedef struct packed {
        logic                      cmd;
        logic [CH_W-1:0]           channel;
        logic signed [PRESS_W-1:0] pressure;
        logic signed [TGT_W-1:0]   target;
        logic                      last_channel;
    } scaled_t;

    typedef struct packed {
        logic [14:0]        dead_band_upper;
        logic signed [15:0] dead_band_lower;
        logic [7:0]         channel_lock_mask;
        logic               control_enable;
    } cfg_t;

    typedef struct packed {
        logic [15:0] valve_word;
        logic [1:0]  pump_bits;
        logic        all_stable;
        logic        start_settle_timer;
        logic [1:0]  led_event;
    } result_t;

endpackage
`default_nettype wire

@@ src/deadzone_pressure_valve_control.sv @@
// Bang-bang pressure valve controller with a dead zone. Each input item is
// either one channel's sample or a settle-timer expiry; a sample that ends a
// sweep (tlast) while control is enabled and every expiry produce one result
// item. The block takes one item per clock cycle while results are taken, and
// an item passes these registers in order before its result is offered: the
// input register, the output register of the constant multiplier that scales
// the ADC reading, and the result register, loaded through the error compare
// and state update. A result that is not taken holds the whole pipeline, so
// input tready follows the output side.
`default_nettype none
`include "deadzone_pressure_valve_control_macros.svh"
module deadzone_pressure_valve_control
    import dpvc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // channel[2:0], adc_value[14:3], zero_value[26:15], target_pressure[42:27]
    input  wire logic [47:0]           s_axis_tdata,
    // cmd
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // valve_word[15:0], pump_bits[17:16], all_stable[18],
    // start_settle_timer[19], led_event[21:20]
    output logic [23:0]                m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    sample_t in_item;
    logic    advance;
    logic    scaled_valid;
    scaled_t scaled_item;
    logic    result_valid;
    result_t result;

    assign advance = !result_valid || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        in_item.cmd = s_axis_tuser;
        in_item.channel = s_axis_tdata[2:0];
        in_item.adc_value = s_axis_tdata[14:3];
        in_item.zero_value = s_axis_tdata[26:15];
        in_item.target_pressure = $signed(s_axis_tdata[42:27]);
        in_item.last_channel = s_axis_tlast;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_DB_UPPER:  cfg_next.dead_band_upper = cfg_data[14:0];
                REG_DB_LOWER:  cfg_next.dead_band_lower = $signed(cfg_data[15:0]);
                REG_LOCK_MASK: cfg_next.channel_lock_mask = cfg_data[7:0];
                REG_ENABLE:    cfg_next.control_enable = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_band_upper <= DB_UPPER_RESET;
            cfg_reg.dead_band_lower <= DB_LOWER_RESET;
            cfg_reg.channel_lock_mask <= '0;
            cfg_reg.control_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpvc_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (s_axis_tvalid),
        .in_item      (in_item),
        .scaled_valid (scaled_valid),
        .scaled_item  (scaled_item)
    );

    dpvc_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg_reg),
        .scaled_valid (scaled_valid),
        .scaled_item  (scaled_item),
        .result_valid (result_valid),
        .result       (result)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tdata = {2'b00, result.led_event, result.start_settle_timer,
                           result.all_stable, result.pump_bits, result.valve_word};

    `DPVC_ASSERT_IMPL(a_stall_holds_input, result_valid && !m_axis_tready, !s_axis_tready)
    `DPVC_ASSERT_IMPL(a_start_needs_stable, result_valid && result.start_settle_timer, result.all_stable)
    `DPVC_ASSERT_IMPL(a_pumps_paired, result_valid, result.pump_bits == 2'b00 || result.pump_bits == 2'b11)
    `DPVC_ASSERT_IMPL(a_valves_exclusive, result_valid, (result.valve_word[7:0] & result.valve_word[15:8]) == 8'h00)

endmodule
`default_nettype wire

@@ src/dpvc_scale.sv @@
`default_nettype none
module dpvc_scale
    import dpvc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire logic    in_valid,
    input  wire sample_t in_item,
    output logic         scaled_valid,
    output scaled_t      scaled_item
);

    logic    in_valid_reg;
    sample_t in_reg;
    logic    p_valid_reg;
    scaled_t p_reg;
    scaled_t p_next;

    logic signed [ADC_W:0]    diff;
    logic signed [PROD_W-1:0] prod;

    always_comb
    begin
        diff = $signed({1'b0, in_reg.adc_value}) - $signed({1'b0, in_reg.zero_value});
        prod = PROD_W'(diff) * PROD_W'(PRESS_MUL);
        p_next.cmd = in_reg.cmd;
        p_next.channel = in_reg.channel;
        p_next.last_channel = in_reg.last_channel;
        // Arithmetic shift gives the floor of the division by 256.
        p_next.pressure = prod[PROD_W-1:8];
        if (in_reg.target_pressure > TARGET_LIMIT)
        begin
            p_next.target = TARGET_LIMIT;
        end
        else if (in_reg.target_pressure < -TARGET_LIMIT)
        begin
            p_next.target = -TARGET_LIMIT;
        end
        else
        begin
            p_next.target = in_reg.target_pressure;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
            p_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_reg <= in_item;
            p_reg <= p_next;
        end
    end

    assign scaled_valid = p_valid_reg;
    assign scaled_item = p_reg;

endmodule
`default_nettype wire

@@ src/dpvc_decide.sv @@
`default_nettype none
module dpvc_decide
    import dpvc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire cfg_t    cfg,
    input  wire logic    scaled_valid,
    input  wire scaled_t scaled_item,
    output logic         result_valid,
    output result_t      result
);

    logic [15:0] valve_reg;
    logic [15:0] valve_next;
    logic [1:0]  pump_reg;
    logic [1:0]  pump_next;
    logic [7:0]  stable_reg;
    logic [7:0]  stable_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     out_next;

    logic signed [ERR_W-1:0] err;
    logic                    in_range;
    logic                    all_next;
    logic                    emit;

    always_comb
    begin
        err = ERR_W'(scaled_item.target) - ERR_W'(scaled_item.pressure);
        in_range = {1'b0, scaled_item.channel} < 4'(CHANNELS);
        valve_next = valve_reg;
        pump_next = pump_reg;
        stable_next = stable_reg;
        emit = 1'b0;
        if (scaled_valid)
        begin
            if (scaled_item.cmd)
            begin
                valve_next = '0;
                pump_next = '0;
                emit = 1'b1;
            end
            else if (cfg.control_enable)
            begin
                if (in_range)
                begin
                    valve_next[{1'b0, scaled_item.channel}] = 1'b0;
                    valve_next[{1'b1, scaled_item.channel}] = 1'b0;
                    if (cfg.channel_lock_mask[scaled_item.channel])
                    begin
                        stable_next[scaled_item.channel] = 1'b1;
                    end
                    else if (err < ERR_W'(cfg.dead_band_lower))
                    begin
                        valve_next[{1'b0, scaled_item.channel}] = 1'b1;
                        pump_next = 2'b11;
                        stable_next[scaled_item.channel] = 1'b0;
                    end
                    else if (err > $signed({6'b0, cfg.dead_band_upper}))
                    begin
                        valve_next[{1'b1, scaled_item.channel}] = 1'b1;
                        pump_next = 2'b11;
                        stable_next[scaled_item.channel] = 1'b0;
                    end
                    else
                    begin
                        stable_next[scaled_item.channel] = 1'b1;
                    end
                end
                emit = scaled_item.last_channel;
            end
        end
        all_next = (stable_next & CHAN_MASK) == CHAN_MASK;
    end

    // Settle phase sequencing at the end of a sweep.
    always_comb
    begin
        phase_next = phase_reg;
        if (scaled_valid && !scaled_item.cmd && emit)
        begin
            if (all_next)
            begin
                if (phase_reg == PH_READY)
                begin
                    phase_next = PH_ARMED;
                end
            end
            else if (phase_reg == PH_DONE)
            begin
                phase_next = PH_READY;
            end
            if (phase_next == PH_ARMED)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = emit;
        out_next.valve_word = valve_next;
        out_next.pump_bits = pump_next;
        out_next.all_stable = all_next;
        out_next.start_settle_timer = 1'b0;
        out_next.led_event = LED_NONE;
        if (!scaled_item.cmd)
        begin
            if (all_next && phase_reg == PH_READY)
            begin
                out_next.led_event = LED_STEADY;
            end
            else if (!all_next && phase_reg == PH_DONE)
            begin
                out_next.led_event = LED_BLINK;
            end
            out_next.start_settle_timer = (phase_reg == PH_ARMED)
                || (all_next && phase_reg == PH_READY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valve_reg <= '0;
            pump_reg <= '0;
            stable_reg <= '0;
            phase_reg <= PH_READY;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valve_reg <= valve_next;
            pump_reg <= pump_next;
            stable_reg <= stable_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

@@ tb/deadzone_pressure_valve_control_test.sv @@
module deadzone_pressure_valve_control_test;
    import dpvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_DB_UPPER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [15:0] valve_state = '0;
    logic [1:0] pump_state = '0;
    logic [7:0] stable_state = '0;
    phase_t settle_state = PH_READY;
    int band_upper = 2560;
    int band_lower = -2560;
    logic [7:0] lock_mask = '0;
    logic ctrl_enable = 1'b0;

    sample_t pending_items[$];
    result_t expected_results[$];
    sample_t offered;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    logic hold_req = 1'b0;
    int hold_count = 0;
    int error_count = 0;
    int cycle_count = 0;

    deadzone_pressure_valve_control dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int scale_adc(input logic [11:0] adc, input logic [11:0] zero);
        int diff;
        diff = int'(adc) - int'(zero);
        return (diff * int'(PRESS_MUL)) >>> 8;
    endfunction

    function automatic bit predict_item(input sample_t it, output result_t res);
        int ch;
        int tgt;
        int err;
        logic all;
        logic start;
        led_t led;
        if (it.cmd)
        begin
            valve_state = '0;
            pump_state = '0;
        end
        else
        begin
            if (!ctrl_enable)
                return 1'b0;
            ch = int'(it.channel);
            valve_state[ch] = 1'b0;
            valve_state[ch + 8] = 1'b0;
            if (lock_mask[ch])
            begin
                stable_state[ch] = 1'b1;
            end
            else
            begin
                tgt = int'($signed(it.target_pressure));
                if (tgt > int'(TARGET_LIMIT))
                    tgt = int'(TARGET_LIMIT);
                if (tgt < -int'(TARGET_LIMIT))
                    tgt = -int'(TARGET_LIMIT);
                err = tgt - scale_adc(it.adc_value, it.zero_value);
                if (err < band_lower)
                begin
                    valve_state[ch] = 1'b1;
                    pump_state = 2'b11;
                    stable_state[ch] = 1'b0;
                end
                else if (err > band_upper)
                begin
                    valve_state[ch + 8] = 1'b1;
                    pump_state = 2'b11;
                    stable_state[ch] = 1'b0;
                end
                else
                begin
                    stable_state[ch] = 1'b1;
                end
            end
            if (!it.last_channel)
                return 1'b0;
        end
        all = ((stable_state & CHAN_MASK) == CHAN_MASK);
        start = 1'b0;
        led = LED_NONE;
        if (!it.cmd)
        begin
            if (all)
            begin
                if (settle_state == PH_READY)
                begin
                    settle_state = PH_ARMED;
                    led = LED_STEADY;
                end
            end
            else if (settle_state == PH_DONE)
            begin
                settle_state = PH_READY;
                led = LED_BLINK;
            end
            if (settle_state == PH_ARMED)
            begin
                start = 1'b1;
                settle_state = PH_DONE;
            end
        end
        res.valve_word = valve_state;
        res.pump_bits = pump_state;
        res.all_stable = all;
        res.start_settle_timer = start;
        res.led_event = led;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : drive_proc
        bit busy;
        result_t res;
        if (rst_n)
        begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_item(offered, res))
                    expected_results.push_back(res);
                busy = 1'b0;
            end
            if (!busy && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offered = pending_items.pop_front();
                s_axis_tdata <= {5'd0, offered.target_pressure, offered.zero_value,
                                 offered.adc_value, offered.channel};
                s_axis_tuser <= offered.cmd;
                s_axis_tlast <= offered.last_channel;
                busy = 1'b1;
            end
            s_axis_tvalid <= busy;
        end
    end

    always @(posedge clk)
    begin : watch_proc
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item %h arrived with none expected", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("valve_word", want.valve_word, m_axis_tdata[15:0]);
                    check_field("pump_bits", 16'(want.pump_bits), 16'(m_axis_tdata[17:16]));
                    check_field("all_stable", 16'(want.all_stable), 16'(m_axis_tdata[18]));
                    check_field("start_settle_timer", 16'(want.start_settle_timer),
                                16'(m_axis_tdata[19]));
                    check_field("led_event", 16'(want.led_event), 16'(m_axis_tdata[21:20]));
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver holds off once for a long stretch when asked to.
    always @(posedge clk)
    begin : hold_proc
        if (hold_off)
        begin
            hold_count <= hold_count + 1;
            if (hold_count >= LONG_HOLD)
                hold_off <= 1'b0;
        end
        else if (hold_req && hold_count == 0)
        begin
            hold_off <= 1'b1;
            hold_count <= 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("deadzone_pressure_valve_control_test: errors");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DB_UPPER: band_upper = int'(value[14:0]);
            REG_DB_LOWER: band_lower = int'($signed(value));
            REG_LOCK_MASK: lock_mask = value[7:0];
            REG_ENABLE: ctrl_enable = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int upper, input int lower, input logic [7:0] mask,
                              input logic en);
        write_reg(REG_DB_UPPER, 16'(upper));
        write_reg(REG_DB_LOWER, 16'(lower));
        write_reg(REG_LOCK_MASK, {8'd0, mask});
        write_reg(REG_ENABLE, {15'd0, en});
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_sample(input logic cmd, input logic [2:0] ch, input logic [11:0] adc,
                               input logic [11:0] zero, input logic [15:0] tgt,
                               input logic last);
        sample_t s;
        s.cmd = cmd;
        s.channel = ch;
        s.adc_value = adc;
        s.zero_value = zero;
        s.target_pressure = tgt;
        s.last_channel = last;
        pending_items.push_back(s);
    endtask

    // Most items form sweeps over the channels with targets near the measured pressure,
    // so that all-stable sweeps and the settle sequence are reached; the rest is noise.
    task automatic queue_random(input int count);
        int produced;
        int kind;
        int len;
        int zero;
        int adc;
        int offset;
        int target;
        bit tight;
        bit last;
        @(negedge clk);
        produced = 0;
        while (produced < count)
        begin
            kind = $urandom_range(99);
            if (kind < 16)
            begin
                push_sample(kind < 8 ? 1'($urandom) : 1'b1, 3'($urandom), 12'($urandom),
                            12'($urandom), 16'($urandom), 1'($urandom));
                produced++;
            end
            else
            begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 8;
                tight = 1'($urandom);
                for (int c = 0; c < len; c++)
                begin
                    zero = $urandom_range(4095);
                    adc = $urandom_range(1000);
                    adc = zero + adc - 500;
                    if (adc < 0)
                        adc = 0;
                    if (adc > 4095)
                        adc = 4095;
                    offset = tight ? $urandom_range(4000) : $urandom_range(12000);
                    offset = offset - (tight ? 2000 : 6000);
                    target = scale_adc(12'(adc), 12'(zero)) + offset;
                    if ($urandom_range(7) == 0)
                        target = $urandom_range(65535) - 32768;
                    if (target > 32767)
                        target = 32767;
                    if (target < -32768)
                        target = -32768;
                    last = (c == len - 1) && ($urandom_range(19) != 0);
                    push_sample(1'b0, 3'(c), 12'(adc), 12'(zero), 16'(target), last);
                end
                produced += len;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_sample(1'b0, 3'd3, 12'd100, 12'd200, 16'd0, 1'b1);
        push_sample(1'b1, 3'd5, 12'd4095, 12'd0, 16'h8000, 1'b0);
        wait_idle();

        set_config(2560, -2560, 8'h00, 1'b1);
        @(negedge clk);
        for (int c = 0; c < 8; c++)
            push_sample(1'b0, 3'(c), 12'd2048, 12'd2048, 16'd0, c == 7);
        for (int c = 0; c < 8; c++)
            push_sample(1'b0, 3'(c), 12'd1500, 12'd1500, 16'd100, c == 7);
        push_sample(1'b0, 3'd0, 12'd4095, 12'd0, 16'h8000, 1'b1);
        push_sample(1'b0, 3'd1, 12'd0, 12'd4095, 16'h7fff, 1'b1);
        push_sample(1'b1, 3'($urandom), 12'($urandom), 12'($urandom), 16'($urandom), 1'b1);
        push_sample(1'b0, 3'd2, 12'd4095, 12'd4095, 16'h7fff, 1'b1);
        push_sample(1'b0, 3'd3, 12'd1000, 12'd1000, 16'd2560, 1'b1);
        push_sample(1'b0, 3'd4, 12'd1000, 12'd1000, 16'd2561, 1'b1);
        push_sample(1'b0, 3'd5, 12'd1000, 12'd1000, -16'sd2560, 1'b1);
        push_sample(1'b0, 3'd6, 12'd1000, 12'd1000, -16'sd2561, 1'b1);
        wait_idle();

        set_config(2560, -2560, 8'h05, 1'b1);
        @(negedge clk);
        push_sample(1'b0, 3'd0, 12'd4095, 12'd0, 16'h8000, 1'b0);
        push_sample(1'b0, 3'd2, 12'd0, 12'd4095, 16'h7fff, 1'b1);
        wait_idle();

        set_config(2560, -2560, 8'h00, 1'b1);
        queue_random(350);
        wait_idle();

        set_config(0, 0, 8'h00, 1'b1);
        send_idle_pct = 63;
        queue_random(300);
        wait_idle();

        set_config(32767, -32768, 8'hff, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        queue_random(250);
        wait_idle();

        set_config($urandom_range(32767), -int'($urandom_range(32768)),
                   8'($urandom_range(255)), 1'b1);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        queue_random(300);
        wait_idle();

        set_config(1000, -4000, 8'h30, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_req <= 1'b1;
        queue_random(150);
        wait (hold_count > LONG_HOLD);
        wait_idle();

        write_reg(REG_ENABLE, 16'd0);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        queue_random(100);
        wait_idle();

        set_config(2560, -2560, 8'h00, 1'b1);
        queue_random(300);
        wait_idle();

        if (error_count == 0)
            $display("deadzone_pressure_valve_control_test: clean");
        else
            $display("deadzone_pressure_valve_control_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/dpvc_pkg.sv
src/dpvc_scale.sv
src/dpvc_decide.sv
src/deadzone_pressure_valve_control.sv
tb/deadzone_pressure_valve_control_test.sv
